// ===== sv/lcdg_pkg.sv =====
// Shared types, constants and the 5x7 font table for the LCD text glyph writer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lcdg_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int GLYPH_COUNT     = 95;

    localparam logic [7:0] GLYPH_FIRST = 8'h20;
    localparam logic [7:0] GLYPH_LAST  = 8'h7E;
    localparam logic [7:0] CODE_BLANK  = 8'h00;
    localparam logic [7:0] CELL_MAX    = 8'd21;
    localparam logic [7:0] PAGE_BASE   = 8'hB0;
    localparam logic [7:0] COL_HI_BASE = 8'h10;
    localparam logic [7:0] CELL_PITCH  = 8'd6;

    // One drawing request for the back end.
    typedef struct packed {
        logic [7:0]  page_cmd;
        logic [7:0]  column;
        logic        glyph;
        logic [39:0] font;     // first glyph column in the top byte
    } t_cmd;

    localparam logic [39:0] FONT_ROM [0:GLYPH_COUNT-1] = '{
        40'h0000000000, 40'h00004f0000, 40'h0007000700, 40'h147f147f14,
        40'h242a7f2a12, 40'h2313086462, 40'h3649552250, 40'h0005070000,
        40'h001c224100, 40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
        40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
        40'h3649494936, 40'h064949291e, 40'h0036360000, 40'h0056360000,
        40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
        40'h324979413e, 40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
        40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
        40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241,
        40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
        40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931,
        40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f,
        40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
        40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040,
        40'h0102040000, 40'h2054545478, 40'h7f48484830, 40'h3844444444,
        40'h304848487f, 40'h3854545458, 40'h00087e0902, 40'h485454543c,
        40'h7f08080870, 40'h00007a0000, 40'h2040403d00, 40'h7f20284400,
        40'h00417f4000, 40'h7c0438047c, 40'h7c08040478, 40'h3844444438,
        40'h7c14141408, 40'h081414147c, 40'h7c08040408, 40'h4854545424,
        40'h04043f4424, 40'h3c4040403c, 40'h1c2040201c, 40'h3c4030403c,
        40'h4428102844, 40'h0448300804, 40'h4464544c44, 40'h0836414100,
        40'h0000770000, 40'h0041413608, 40'h0402020201
    };

endpackage

// ===== sv/lcdg_front.sv =====
// Front end: accepts stream items, drops those that draw nothing, and builds
// the page, column and font word of a request. Depends on lcdg_pkg.
`timescale 1ns / 1ps

module lcdg_front
    import lcdg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [3:0]  i_text_row,
    input  logic [7:0]  i_char_cell,
    input  logic [7:0]  i_char_code,
    output logic        o_cmd_valid,
    input  logic        i_cmd_ready,
    output t_cmd        o_cmd
);

    logic        r_valid, n_valid;
    t_cmd        r_cmd, n_cmd;
    logic        accept;
    logic        is_glyph;
    logic        is_good;
    logic [6:0]  glyph_idx;
    logic [7:0]  page_cmd;
    logic [7:0]  column;

    assign o_ready     = !r_valid || i_cmd_ready;
    assign accept      = i_valid && o_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_comb begin
        is_glyph  = (i_char_code >= GLYPH_FIRST) && (i_char_code <= GLYPH_LAST);
        is_good   = (i_char_cell <= CELL_MAX) && (is_glyph || (i_char_code == CODE_BLANK));
        glyph_idx = is_glyph ? 7'(i_char_code - GLYPH_FIRST) : 7'd0;
        page_cmd  = PAGE_BASE + {4'h0, i_text_row} + 8'hFF;
        column    = 8'd1 + 8'(i_char_cell * CELL_PITCH);
    end

    always_comb begin
        n_valid = r_valid;
        n_cmd   = r_cmd;
        if (accept) begin
            n_valid        = is_good;
            n_cmd.page_cmd = page_cmd;
            n_cmd.column   = column;
            n_cmd.glyph    = is_glyph;
            n_cmd.font     = FONT_ROM[glyph_idx];
        end else if (i_cmd_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_cmd <= n_cmd;
    end

endmodule

// ===== sv/lcdg_queue.sv =====
// Request queue between front and back end, a small register FIFO.
// Depends on lcdg_pkg for the request type.
`timescale 1ns / 1ps

module lcdg_queue
    import lcdg_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_cmd i_push_data,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_cmd o_pop_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;
    logic          push;
    logic          pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        priority if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
        if (push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

// ===== sv/lcdg_back.sv =====
// Back end: walks one request through its command and data bytes and drives
// the registered output stream. Depends on lcdg_pkg.
`timescale 1ns / 1ps

module lcdg_back
    import lcdg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    output logic       o_cmd_ready,
    input  t_cmd       i_cmd,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_lcd_byte,
    output logic       o_is_data,
    output logic       o_last
);

    typedef enum logic [3:0] {
        ST_PAGE, ST_COL_HI, ST_COL_LO,
        ST_G0, ST_G1, ST_G2, ST_G3, ST_G4, ST_GAP
    } t_step;

    t_step      r_step, n_step;
    logic       r_valid, n_valid;
    logic [7:0] r_byte, n_byte;
    logic       r_data, n_data;
    logic       r_last, n_last;
    logic       out_free;
    logic       go;
    logic       pop;

    assign out_free    = !r_valid || i_ready;
    assign go          = i_cmd_valid && out_free;
    assign o_cmd_ready = pop;
    assign o_valid     = r_valid;
    assign o_lcd_byte  = r_byte;
    assign o_is_data   = r_data;
    assign o_last      = r_last;

    always_comb begin
        n_step  = r_step;
        n_valid = r_valid && !i_ready;
        n_byte  = r_byte;
        n_data  = r_data;
        n_last  = r_last;
        pop     = 1'b0;
        if (go) begin
            n_valid = 1'b1;
            n_data  = 1'b1;
            n_last  = 1'b0;
            unique case (r_step)
                ST_PAGE: begin
                    n_byte = i_cmd.page_cmd;
                    n_data = 1'b0;
                end
                ST_COL_HI: begin
                    n_byte = COL_HI_BASE + {4'h0, i_cmd.column[7:4]};
                    n_data = 1'b0;
                end
                ST_COL_LO: begin
                    n_byte = {4'h0, i_cmd.column[3:0]};
                    n_data = 1'b0;
                end
                ST_G0: n_byte = i_cmd.glyph ? i_cmd.font[39:32] : 8'h00;
                ST_G1: n_byte = i_cmd.glyph ? i_cmd.font[31:24] : 8'h00;
                ST_G2: n_byte = i_cmd.glyph ? i_cmd.font[23:16] : 8'h00;
                ST_G3: n_byte = i_cmd.glyph ? i_cmd.font[15:8]  : 8'h00;
                ST_G4: begin
                    n_byte = i_cmd.glyph ? i_cmd.font[7:0] : 8'h00;
                    n_last = !i_cmd.glyph;
                end
                ST_GAP: begin
                    n_byte = 8'h00;
                    n_last = 1'b1;
                end
                default: begin
                    n_byte = 8'h00;
                    n_last = 1'b1;
                end
            endcase
            if (n_last) begin
                n_step = ST_PAGE;
                pop    = 1'b1;
            end else begin
                n_step = t_step'(r_step + 4'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= ST_PAGE;
            r_valid <= 1'b0;
        end else begin
            r_step  <= n_step;
            r_valid <= n_valid;
        end
        r_byte <= n_byte;
        r_data <= n_data;
        r_last <= n_last;
    end

    a_gap_only_for_glyph: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == ST_GAP) |-> (!i_cmd_valid || i_cmd.glyph))
        else $error("gap column reached for a blank cell");

    a_run_opens_with_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && r_step == ST_PAGE) |=> (r_valid && !r_data))
        else $error("run did not open with a command byte");

    a_last_is_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_last) |-> r_data)
        else $error("last byte of a run is not display data");

    a_pop_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> (r_step == ST_PAGE && r_last))
        else $error("request released before its last byte");

endmodule

// ===== sv/lcd_text_glyph_writer.sv =====
// Top level of the LCD text glyph writer: front end, request queue, back end.
// Depends on lcdg_pkg, lcdg_front, lcdg_queue and lcdg_back.
`timescale 1ns / 1ps

// Each accepted item (row, cell, code) becomes a run of bytes for a
// page-addressed LCD: page, column-high and column-low commands, then five
// font columns and one blank column for codes 0x20..0x7E (9 bytes), or five
// blank columns for code 0 (8 bytes). Cells above 21 and other codes are
// accepted and dropped. The back end sends one byte per cycle while the
// receiver is ready; the input keeps taking items one per cycle until the
// request queue and the front register are full, then follows the output rate.

module lcd_text_glyph_writer
    import lcdg_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // text_row[3:0], char_cell[11:4], char_code[19:12]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // lcd_byte[7:0]
    output logic        m_axis_tuser,   // is_data[0]
    output logic        m_axis_tlast
);

    logic front_valid;
    logic front_ready;
    t_cmd front_cmd;
    logic queue_valid;
    logic queue_ready;
    t_cmd queue_cmd;

    lcdg_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_text_row  (s_axis_tdata[3:0]),
        .i_char_cell (s_axis_tdata[11:4]),
        .i_char_code (s_axis_tdata[19:12]),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (front_ready),
        .o_cmd       (front_cmd)
    );

    lcdg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_data  (front_cmd),
        .o_pop_valid  (queue_valid),
        .i_pop_ready  (queue_ready),
        .o_pop_data   (queue_cmd)
    );

    lcdg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (queue_valid),
        .o_cmd_ready (queue_ready),
        .i_cmd       (queue_cmd),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_lcd_byte  (m_axis_tdata),
        .o_is_data   (m_axis_tuser),
        .o_last      (m_axis_tlast)
    );

endmodule

// ===== test/testbench.sv =====
// Self-checking bench for lcd_text_glyph_writer: directed rows, then random requests.
// Depends on lcdg_pkg (types, constants, font table) and the block's RTL.
`timescale 1ns / 1ps

module testbench;
    import lcdg_pkg::*;

    localparam int N_RANDOM    = 308;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AFTER  = 300;
    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN_WAIT  = 32;
    localparam int N_DIR       = 22;

    typedef struct packed {
        logic [7:0] lcd_byte;
        logic       is_data;
        logic       last_of_run;
    } lcd_beat_t;

    typedef struct packed {
        logic [3:0] row;
        logic [7:0] char_cell;
        logic [7:0] code;
        logic       typed;
        logic [7:0] page_cmd;
        logic [7:0] col_hi;
        logic [7:0] col_lo;
        logic [3:0] n_beats;
    } dir_req_t;

    localparam dir_req_t DIR_TAB [0:N_DIR-1] = '{
        '{4'd1,  8'd0,   8'h00, 1'b1, 8'hB0, 8'h10, 8'h01, 4'd8},
        '{4'd8,  8'd21,  8'h00, 1'b1, 8'hB7, 8'h17, 8'h0F, 4'd8},
        '{4'd1,  8'd0,   8'h20, 1'b1, 8'hB0, 8'h10, 8'h01, 4'd9},
        '{4'd0,  8'd5,   8'h00, 1'b1, 8'hAF, 8'h11, 8'h0F, 4'd8},
        '{4'd15, 8'd10,  8'h20, 1'b1, 8'hBE, 8'h13, 8'h0D, 4'd9},
        '{4'd9,  8'd3,   8'h7E, 1'b0, 8'h00, 8'h00, 8'h00, 4'd0},
        '{4'd4,  8'd22,  8'h41, 1'b1, 8'h00, 8'h00, 8'h00, 4'd0},
        '{4'd4,  8'd255, 8'h00, 1'b1, 8'h00, 8'h00, 8'h00, 4'd0},
        '{4'd2,  8'd7,   8'h7F, 1'b1, 8'h00, 8'h00, 8'h00, 4'd0},
        '{4'd2,  8'd7,   8'hFF, 1'b1, 8'h00, 8'h00, 8'h00, 4'd0},
        '{4'd3,  8'd7,   8'h1F, 1'b1, 8'h00, 8'h00, 8'h00, 4'd0},
        '{4'd3,  8'd7,   8'h01, 1'b1, 8'h00, 8'h00, 8'h00, 4'd0},
        '{4'd0,  8'd21,  8'hFF, 1'b1, 8'h00, 8'h00, 8'h00, 4'd0},
        '{4'd15, 8'd255, 8'hFF, 1'b1, 8'h00, 8'h00, 8'h00, 4'd0},
        '{4'd5,  8'd1,   8'h21, 1'b0, 8'h00, 8'h00, 8'h00, 4'd0},
        '{4'd6,  8'd2,   8'h41, 1'b0, 8'h00, 8'h00, 8'h00, 4'd0},
        '{4'd7,  8'd11,  8'h7D, 1'b0, 8'h00, 8'h00, 8'h00, 4'd0},
        '{4'd8,  8'd20,  8'h5A, 1'b0, 8'h00, 8'h00, 8'h00, 4'd0},
        '{4'd10, 8'd16,  8'h30, 1'b0, 8'h00, 8'h00, 8'h00, 4'd0},
        '{4'd12, 8'd0,   8'h61, 1'b0, 8'h00, 8'h00, 8'h00, 4'd0},
        '{4'd14, 8'd21,  8'h7E, 1'b0, 8'h00, 8'h00, 8'h00, 4'd0},
        '{4'd1,  8'd21,  8'h7E, 1'b0, 8'h00, 8'h00, 8'h00, 4'd0}
    };

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    lcd_beat_t lcd_exp_q [$];
    int        n_errors   = 0;
    int        n_beats_rx = 0;

    lcd_text_glyph_writer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        n_errors++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic void push_beat(input logic [7:0] b, input logic d, input logic l);
        lcd_beat_t beat;
        beat.lcd_byte    = b;
        beat.is_data     = d;
        beat.last_of_run = l;
        lcd_exp_q.push_back(beat);
    endfunction

    // Push the byte run one request draws; return its length.
    function automatic int predict_lcd_run(input logic [3:0] row, input logic [7:0] char_cell,
                                           input logic [7:0] code);
        logic [7:0]  column;
        logic [39:0] glyph_bits;
        logic        drawn;
        if (char_cell > CELL_MAX) return 0;
        drawn = (code >= GLYPH_FIRST) && (code <= GLYPH_LAST);
        if (!drawn && code != CODE_BLANK) return 0;
        column = 8'(8'd1 + char_cell * CELL_PITCH);
        push_beat(8'(PAGE_BASE + {4'h0, row} - 8'd1), 1'b0, 1'b0);
        push_beat(COL_HI_BASE + (column >> 4), 1'b0, 1'b0);
        push_beat(column & 8'h0F, 1'b0, 1'b0);
        if (drawn) begin
            glyph_bits = FONT_ROM[code - GLYPH_FIRST];
            for (int k = 0; k < 5; k++) begin
                push_beat(glyph_bits[39 - 8 * k -: 8], 1'b1, 1'b0);
            end
            push_beat(8'h00, 1'b1, 1'b1);
            return 9;
        end
        for (int k = 0; k < 5; k++) begin
            push_beat(8'h00, 1'b1, k == 4);
        end
        return 8;
    endfunction

    task automatic send_request(input logic [3:0] row, input logic [7:0] char_cell,
                                input logic [7:0] code, input int gap);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'h0, code, char_cell, row};
        do @(posedge i_clk); while (!s_axis_tready);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        lcd_beat_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_beats_rx <= n_beats_rx + 1;
            if (lcd_exp_q.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %02h", m_axis_tdata));
            end else begin
                want = lcd_exp_q.pop_front();
                if (m_axis_tdata !== want.lcd_byte)
                    report_mismatch($sformatf("lcd_byte %02h, want %02h",
                                              m_axis_tdata, want.lcd_byte));
                if (m_axis_tuser !== want.is_data)
                    report_mismatch($sformatf("is_data %b, want %b",
                                              m_axis_tuser, want.is_data));
                if (m_axis_tlast !== want.last_of_run)
                    report_mismatch($sformatf("last_of_run %b, want %b",
                                              m_axis_tlast, want.last_of_run));
            end
        end
    end

    // Receiver: random ready runs and gaps, one long hold to back up the input.
    initial begin
        int  run_len;
        int  gap;
        bit  held;
        held = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            m_axis_tready <= 1'b1;
            run_len = $urandom_range(1, 30);
            repeat (run_len) @(posedge i_clk);
            if (!held && n_beats_rx >= HOLD_AFTER) begin
                gap  = HOLD_CYCLES;
                held = 1'b1;
            end else begin
                gap = pick_gap();
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no request moved for %0d cycles", IDLE_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int         n_item;
        int         r;
        int         gap;
        logic [3:0] row;
        logic [7:0] char_cell;
        logic [7:0] code;
        dir_req_t   d;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIR; i++) begin
            d = DIR_TAB[i];
            if (d.typed) begin
                if (d.n_beats != 0) begin
                    push_beat(d.page_cmd, 1'b0, 1'b0);
                    push_beat(d.col_hi, 1'b0, 1'b0);
                    push_beat(d.col_lo, 1'b0, 1'b0);
                    for (int k = 3; k < d.n_beats; k++) begin
                        push_beat(8'h00, 1'b1, k == d.n_beats - 1);
                    end
                end
            end else begin
                void'(predict_lcd_run(d.row, d.char_cell, d.code));
            end
            send_request(d.row, d.char_cell, d.code, pick_gap());
        end

        n_item = 0;
        while (n_item < N_RANDOM) begin
            r         = $urandom_range(0, 99);
            row       = (r < 85) ? 4'($urandom_range(1, 8)) : 4'($urandom_range(0, 15));
            r         = $urandom_range(0, 99);
            char_cell = (r < 88) ? 8'($urandom_range(0, 21)) : 8'($urandom_range(0, 255));
            r         = $urandom_range(0, 99);
            if (r < 12)
                code = CODE_BLANK;
            else if (r < 88)
                code = 8'($urandom_range(GLYPH_FIRST, GLYPH_LAST));
            else
                code = 8'($urandom_range(0, 255));
            void'(predict_lcd_run(row, char_cell, code));
            gap = (n_item % 64 < 12) ? 0 : pick_gap();
            send_request(row, char_cell, code, gap);
            n_item++;
        end
        s_axis_tvalid <= 1'b0;

        while (lcd_exp_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (n_errors == 0 && lcd_exp_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
